// ----- hdl/ecal_pkg.sv -----
// Shared types, constants and helper functions for the epoch-to-calendar block.
// Used by ecal_front, ecal_queue, ecal_back and epoch_seconds_to_calendar_top.
// No dependencies.
package ecal_pkg;

	localparam int unsigned SecsPerDay  = 86400;
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned SecsPerMin  = 60;
	localparam int unsigned DaysPerYear = 365;
	localparam int unsigned BaseYear    = 70;
	localparam int unsigned WeekdayOffs = 4;
	localparam int unsigned LastMonth   = 11;

	// highest quotient bit of each compare-subtract division (steps run from it down to bit 0)
	localparam logic [3:0] DayTopBit  = 4'd15;
	localparam logic [3:0] HourTopBit = 4'd4;
	localparam logic [3:0] MinTopBit  = 4'd5;
	localparam logic [2:0] YearTopBit = 3'd7;

	// request handed from the front to the back through the queue
	typedef struct packed {
		logic [15:0] day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} ecal_item_t;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_DAY,
		FR_HOUR,
		FR_MIN,
		FR_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_YEAR,
		BK_MONTH,
		BK_DONE
	} back_state_t;

	// divisor of the front's current step, shifted to the quotient bit in work
	function automatic logic [31:0] front_divisor(front_state_t st, logic [3:0] k);
		logic [31:0] d;
		unique case (st)
			FR_DAY:  d = 32'(SecsPerDay) << k;
			FR_HOUR: d = 32'(SecsPerHour) << k;
			FR_MIN:  d = 32'(SecsPerMin) << k;
			default: d = '0;
		endcase
		return d;
	endfunction

	// month lengths of the simplified calendar (February always 28 days)
	function automatic logic [4:0] month_len(logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd1:    len = 5'd28;
			4'd3,
			4'd5,
			4'd8,
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// (day + 4) mod 7 by folding octal digits, since 8 is 1 modulo 7
	function automatic logic [2:0] weekday_of(logic [15:0] day);
		logic [17:0] d;
		logic [5:0]  s1;
		logic [3:0]  s2;
		logic [2:0]  w;
		d  = 18'(day) + 18'(WeekdayOffs);
		s1 = 6'(d[2:0]) + 6'(d[5:3]) + 6'(d[8:6]) + 6'(d[11:9])
			+ 6'(d[14:12]) + 6'(d[17:15]);
		s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
		if (s2 >= 4'd7) begin
			s2 = s2 - 4'd7;
		end
		w = s2[2:0];
		return w;
	endfunction

endpackage

// ----- hdl/ecal_front.sv -----
// Front part: accepts a seconds count and splits it into day, hour, minute
// and second with one shared restoring compare-subtract unit.
// Depends on ecal_pkg.
module ecal_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,
	output ecal_pkg::ecal_item_t item,
	output logic               item_valid,
	input  logic               item_ready
);
	import ecal_pkg::*;

	front_state_t state_q, state_d;
	logic [31:0]  rem_q;
	logic [15:0]  quo_q;
	logic [3:0]   k_q;
	logic [15:0]  day_q;
	logic [4:0]   hour_q;
	logic [5:0]   minute_q;
	logic [5:0]   second_q;

	logic [31:0] divisor;
	logic        fits;
	logic [31:0] rem_next;
	logic [15:0] quo_next;

	// one restoring step against the shifted constant
	always_comb begin
		divisor  = front_divisor(state_q, k_q);
		fits     = rem_q >= divisor;
		rem_next = fits ? rem_q - divisor : rem_q;
		quo_next = {quo_q[14:0], fits};
	end

	// next state and handshake
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		item_valid = 1'b0;
		unique case (state_q)
			FR_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = FR_DAY;
				end
			end
			FR_DAY: begin
				if (k_q == '0) begin
					state_d = FR_HOUR;
				end
			end
			FR_HOUR: begin
				if (k_q == '0) begin
					state_d = FR_MIN;
				end
			end
			FR_MIN: begin
				if (k_q == '0) begin
					state_d = FR_PUSH;
				end
			end
			FR_PUSH: begin
				item_valid = 1'b1;
				if (item_ready) begin
					state_d = FR_IDLE;
				end
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// advance the divider and capture each quotient as its phase ends
	always_ff @(posedge clk) begin
		unique case (state_q)
			FR_IDLE: begin
				rem_q <= s_tdata;
				quo_q <= '0;
				k_q   <= DayTopBit;
			end
			FR_DAY: begin
				rem_q <= rem_next;
				if (k_q == '0) begin
					day_q <= quo_next;
					quo_q <= '0;
					k_q   <= HourTopBit;
				end else begin
					quo_q <= quo_next;
					k_q   <= k_q - 4'd1;
				end
			end
			FR_HOUR: begin
				rem_q <= rem_next;
				if (k_q == '0) begin
					hour_q <= quo_next[4:0];
					quo_q  <= '0;
					k_q    <= MinTopBit;
				end else begin
					quo_q <= quo_next;
					k_q   <= k_q - 4'd1;
				end
			end
			FR_MIN: begin
				rem_q <= rem_next;
				if (k_q == '0) begin
					minute_q <= quo_next[5:0];
					second_q <= rem_next[5:0];
				end else begin
					quo_q <= quo_next;
					k_q   <= k_q - 4'd1;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign item.day    = day_q;
	assign item.hour   = hour_q;
	assign item.minute = minute_q;
	assign item.second = second_q;

	// the day phase leaves less than one day of seconds
	a_sod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FR_HOUR && $past(state_q) == FR_DAY) |-> rem_q < 32'(SecsPerDay))
		else $error("seconds of day out of range after day phase");

endmodule

// ----- hdl/ecal_queue.sv -----
// Two-entry queue that decouples the front from the back.
// Depends on ecal_pkg.
module ecal_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  ecal_pkg::ecal_item_t wr_item,
	input  logic               wr_valid,
	output logic               wr_ready,
	output ecal_pkg::ecal_item_t rd_item,
	output logic               rd_valid,
	input  logic               rd_ready
);
	import ecal_pkg::*;

	ecal_item_t  mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_item  = mem_q[rd_ptr_q];

	// move pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// store the request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("queue fill level beyond depth");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill level");

endmodule

// ----- hdl/ecal_back.sv -----
// Back part: turns a day count into weekday, year, day of year, month and
// day of month, and holds the packed result in an output register.
// Depends on ecal_pkg.
module ecal_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ecal_pkg::ecal_item_t item,
	input  logic               item_valid,
	output logic               item_ready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata
);
	import ecal_pkg::*;

	back_state_t state_q, state_d;
	logic [15:0] rem_q;
	logic [7:0]  quo_q;
	logic [2:0]  k_q;
	logic [3:0]  mon_q;
	logic [2:0]  wday_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [7:0]  year_q;
	logic [8:0]  yday_q;
	logic        out_valid_q;
	logic [47:0] out_data_q;

	logic [15:0] divisor;
	logic        fits;
	logic [15:0] rem_next;
	logic [7:0]  quo_next;
	logic [4:0]  mlen;
	logic        adv;
	logic        out_free;
	logic        load_out;

	// year step and month step
	always_comb begin
		divisor  = 16'(DaysPerYear) << k_q;
		fits     = rem_q >= divisor;
		rem_next = fits ? rem_q - divisor : rem_q;
		quo_next = {quo_q[6:0], fits};
		mlen     = month_len(mon_q);
		adv      = (mon_q < 4'(LastMonth)) && (rem_q >= 16'(mlen));
		out_free = !out_valid_q || m_tready;
	end

	// next state and handshake
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = BK_YEAR;
				end
			end
			BK_YEAR: begin
				if (k_q == '0) begin
					state_d = BK_MONTH;
				end
			end
			BK_MONTH: begin
				if (!adv) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work registers of the year division and the month walk
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				rem_q    <= item.day;
				quo_q    <= '0;
				k_q      <= YearTopBit;
				wday_q   <= weekday_of(item.day);
				hour_q   <= item.hour;
				minute_q <= item.minute;
				second_q <= item.second;
			end
			BK_YEAR: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				if (k_q == '0) begin
					year_q <= quo_next + 8'(BaseYear);
					yday_q <= rem_next[8:0];
					mon_q  <= '0;
				end else begin
					k_q <= k_q - 3'd1;
				end
			end
			BK_MONTH: begin
				if (adv) begin
					rem_q <= rem_q - 16'(mlen);
					mon_q <= mon_q + 4'd1;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	// hold the packed result until taken
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {2'b00, rem_q[4:0] + 5'd1, mon_q, yday_q, year_q, wday_q,
				hour_q, minute_q, second_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_month_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_MONTH |-> mon_q <= 4'(LastMonth))
		else $error("month index beyond December");

	a_yday_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MONTH && $past(state_q) == BK_YEAR) |-> rem_q < 16'(DaysPerYear))
		else $error("day of year out of range after year division");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == BK_DONE)
		else $error("result raised outside the completion state");

endmodule

// ----- hdl/epoch_seconds_to_calendar_top.sv -----
// Seconds-since-1970 to broken-down calendar time, 365-day years, 28-day
// February. Input stream s_*: one 32-bit seconds count per request.
// Output stream m_*: one packed calendar result per request, in order.
// The front splits the count into day, hour, minute and second with one
// shared compare-subtract unit (16 + 5 + 6 steps); a two-entry queue passes
// the request to the back, which divides the day count by 365 (8 steps) and
// walks the month table (1 to 12 steps).
// The request rate is set by the front's divider, which ends each request
// by pushing it to the queue before it takes the next.
// s_tready is high only while the front is free. When the receiver stalls
// the result is held in the output register, the back finishes the next
// request and waits, and the queue then fills before the front stops.
// Reset (arst_n low) empties the queue and drops any request in work; no
// clearing pass is needed afterwards.
// Depends on ecal_pkg, ecal_front, ecal_queue and ecal_back.
module epoch_seconds_to_calendar_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] epoch_seconds
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
	// [27:20] years_since_1900, [36:28] day_of_year, [40:37] month,
	// [45:41] day_of_month, [47:46] zero
	output logic [47:0] m_tdata
);
	import ecal_pkg::*;

	ecal_item_t fr_item;
	logic       fr_valid;
	logic       fr_ready;
	ecal_item_t bk_item;
	logic       bk_valid;
	logic       bk_ready;

	ecal_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item       (fr_item),
		.item_valid (fr_valid),
		.item_ready (fr_ready)
	);

	ecal_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (fr_item),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.rd_item  (bk_item),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready)
	);

	ecal_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (bk_item),
		.item_valid (bk_valid),
		.item_ready (bk_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// ----- test/epoch_seconds_to_calendar_top_tb.sv -----
// Testbench for epoch_seconds_to_calendar_top: seconds counts in, calendar results out.
// Directed table then random requests, each result checked against typed or predicted values.
// Depends on hdl/epoch_seconds_to_calendar_top.sv and its sub-blocks.
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_top_tb;

	localparam int unsigned RandomRequests = 1050;
	localparam int unsigned DrainCycles    = 60;
	localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	// result fields, highest bit first, laid out as in m_tdata[45:0]
	typedef struct packed {
		logic [4:0] day_of_month;
		logic [3:0] month;
		logic [8:0] day_of_year;
		logic [7:0] years_since_1900;
		logic [2:0] weekday;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} cal_t;

	typedef struct {
		logic [31:0] secs;
		bit          typed;
		cal_t        cal;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	cal_t        cal_expected [$];
	dir_row_t    dir_rows [$];
	int unsigned mismatch_count = 0;

	epoch_seconds_to_calendar_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 365-day years, 28-day February, day zero a Thursday
	function automatic cal_t calendar_of(logic [31:0] secs);
		int unsigned t;
		int unsigned rem;
		int unsigned mon;
		cal_t c;
		t = secs;
		c.second = 6'(t % 60);
		t = t / 60;
		c.minute = 6'(t % 60);
		t = t / 60;
		c.hour = 5'(t % 24);
		t = t / 24;
		c.weekday = 3'((t + 4) % 7);
		c.years_since_1900 = 8'(70 + t / 365);
		rem = t % 365;
		c.day_of_year = 9'(rem);
		mon = 0;
		while (mon < 11 && rem >= MonthDays[mon]) begin
			rem = rem - MonthDays[mon];
			mon++;
		end
		c.month = 4'(mon);
		c.day_of_month = 5'(rem + 1);
		return c;
	endfunction

	function automatic cal_t make_cal(int unsigned sec, int unsigned mi, int unsigned hr,
			int unsigned wd, int unsigned yr, int unsigned yd, int unsigned mo,
			int unsigned md);
		cal_t c;
		c.second           = 6'(sec);
		c.minute           = 6'(mi);
		c.hour             = 5'(hr);
		c.weekday          = 3'(wd);
		c.years_since_1900 = 8'(yr);
		c.day_of_year      = 9'(yd);
		c.month            = 4'(mo);
		c.day_of_month     = 5'(md);
		return c;
	endfunction

	// mostly no gap, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(30, 80);
	endfunction

	// weight the random counts towards month, year and range edges
	function automatic logic [31:0] rand_epoch();
		int unsigned r;
		int unsigned yr;
		int unsigned mo;
		int unsigned day;
		int unsigned tod;
		longint unsigned v;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return $urandom;
		end else if (r < 8) begin
			yr  = $urandom_range(0, 136);
			mo  = $urandom_range(0, 11);
			day = yr * 365;
			for (int i = 0; i < mo; i++) begin
				day = day + MonthDays[i];
			end
			if (day > 0 && $urandom_range(0, 1) == 1) begin
				day = day - 1;
			end
			case ($urandom_range(0, 2))
				0: tod = 0;
				1: tod = 86399;
				default: tod = $urandom_range(0, 86399);
			endcase
			v = longint'(day) * 86400 + tod;
			if (v > 64'hFFFF_FFFF) begin
				return $urandom;
			end
			return v[31:0];
		end else if (r < 9) begin
			return 32'hFFFF_FFFF - $urandom_range(0, 200000);
		end
		return $urandom_range(0, 100000);
	endfunction

	task automatic add_row(logic [31:0] secs, bit typed, cal_t cal);
		dir_row_t row;
		row.secs  = secs;
		row.typed = typed;
		row.cal   = cal;
		dir_rows.push_back(row);
	endtask

	// offer one request after a gap; called and left at a falling edge
	task automatic send_request(logic [31:0] secs, cal_t cal, int unsigned gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= secs;
		do begin
			@(posedge clk);
		end while (!s_tready);
		cal_expected.push_back(cal);
		@(negedge clk);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result(logic [47:0] data);
		cal_t want;
		cal_t got;
		if (cal_expected.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $realtime, data);
			mismatch_count++;
		end else begin
			want = cal_expected.pop_front();
			got  = data[45:0];
			check_field("second", want.second, got.second);
			check_field("minute", want.minute, got.minute);
			check_field("hour", want.hour, got.hour);
			check_field("weekday", want.weekday, got.weekday);
			check_field("years_since_1900", want.years_since_1900, got.years_since_1900);
			check_field("day_of_year", want.day_of_year, got.day_of_year);
			check_field("month", want.month, got.month);
			check_field("day_of_month", want.day_of_month, got.day_of_month);
			check_field("padding", 0, data[47:46]);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// receiver: random stalls with calm stretches, check each accepted result
	initial begin
		int unsigned stall_left;
		int unsigned cyc;
		bit          calm;
		stall_left = 0;
		cyc        = 0;
		calm       = 1'b0;
		m_tready   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (cyc % 400 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			cyc++;
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!calm) begin
					stall_left = pick_gap();
				end
			end
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				check_result(m_tdata);
			end
		end
	end

	// sender: reset, directed table, random requests, drain
	initial begin
		logic [31:0] secs;
		bit          calm;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extremes typed in, other rows predicted
		add_row(32'd0, 1'b1, make_cal(0, 0, 0, 4, 70, 0, 0, 1));
		add_row(32'd59, 1'b1, make_cal(59, 0, 0, 4, 70, 0, 0, 1));
		add_row(32'd86399, 1'b1, make_cal(59, 59, 23, 4, 70, 0, 0, 1));
		add_row(32'd31536000, 1'b1, make_cal(0, 0, 0, 5, 71, 0, 0, 1));
		add_row(32'hFFFF_FFFF, 1'b1, make_cal(15, 28, 6, 0, 206, 70, 2, 12));
		add_row(32'd60, 1'b0, '0);
		add_row(32'd3599, 1'b0, '0);
		add_row(32'd3600, 1'b0, '0);
		add_row(32'd86400, 1'b0, '0);
		add_row(32'd2678399, 1'b0, '0);
		add_row(32'd2678400, 1'b0, '0);
		add_row(32'd5097599, 1'b0, '0);
		add_row(32'd5097600, 1'b0, '0);
		add_row(32'd28857600, 1'b0, '0);
		add_row(32'd31535999, 1'b0, '0);
		add_row(32'h8000_0000, 1'b0, '0);
		add_row(32'h7FFF_FFFF, 1'b0, '0);
		add_row(32'hAAAA_AAAA, 1'b0, '0);
		add_row(32'h5555_5555, 1'b0, '0);
		add_row(32'hF0F0_F0F0, 1'b0, '0);
		add_row(32'h0F0F_0F0F, 1'b0, '0);
		add_row(32'd4294944000, 1'b0, '0);

		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].secs,
				dir_rows[i].typed ? dir_rows[i].cal : calendar_of(dir_rows[i].secs),
				pick_gap());
		end

		// alternate stretches of back-to-back and gapped requests
		for (int n = 0; n < RandomRequests; n++) begin
			calm = ((n / 150) % 2 == 1);
			secs = rand_epoch();
			send_request(secs, calendar_of(secs), calm ? 0 : pick_gap());
		end
		s_tvalid <= 1'b0;

		while (cal_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/ecal_pkg.sv
hdl/ecal_front.sv
hdl/ecal_queue.sv
hdl/ecal_back.sv
hdl/epoch_seconds_to_calendar_top.sv
test/epoch_seconds_to_calendar_top_tb.sv
